// File: sv/gdoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdoc_pkg: gyro DAC offset calibrator definitions
// Widths, thresholds, level limits, settle waits and the axis-to-channel map.
// ----------------------------------------------------------------------------
package gdoc_pkg;

    localparam int RATE_W   = 16;
    localparam int FACTOR_W = 8;
    localparam int LEVEL_W  = 8;
    localparam int ITER_W   = 8;
    localparam int WAIT_W   = 7;
    localparam int THR_W    = 18;
    localparam int NUM_AXES = 3;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [FACTOR_W-1:0] factor_t;
    typedef logic [RATE_W-1:0]   rate_t;
    typedef logic [ITER_W-1:0]   iter_t;
    typedef logic [WAIT_W-1:0]   wait_t;

    // configuration register indexes
    localparam logic REG_XY_OVS = 1'b0;
    localparam logic REG_Z_OVS  = 1'b1;

    localparam logic [9:0] LOW_MULT  = 10'd510;
    localparam logic [9:0] HIGH_MULT = 10'd515;

    localparam level_t  LEVEL_MIN   = 8'd10;
    localparam level_t  LEVEL_MAX   = 8'd245;
    localparam level_t  LEVEL_RESET = 8'd102;
    localparam factor_t FACTOR_RESET = 8'd4;

    localparam wait_t WAIT_FAST = 7'd2;
    localparam wait_t WAIT_TAIL = 7'd10;
    localparam wait_t WAIT_DONE = 7'd70;

    // axis X, Y, Z drive DAC channels 1, 0, 2
    localparam logic [1:0] AXIS_CHANNEL [NUM_AXES] = '{2'd1, 2'd0, 2'd2};

endpackage

// File: sv/gyro_dac_offset_calibrator.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while m_ready does not hold the result stage; the
// input register and the result register form a two-stage pipeline, and the
// offset state updates as a beat moves into the result register. Reset (aresetn
// low, synchronous) empties both stages, sets all offsets to 102, clears faults,
// loads the iteration count and sets both oversampling factors to 4.
// ----------------------------------------------------------------------------
// gyro_dac_offset_calibrator
// Steps three gyro amplifier offset DACs toward the rate window per sample.
// ----------------------------------------------------------------------------
module gyro_dac_offset_calibrator
    import gdoc_pkg::*;
#(
    parameter int ITERATIONS      = 200,
    parameter int TAIL_ITERATIONS = 10
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic [15:0]  s_rate_x,
    input  logic [15:0]  s_rate_y,
    input  logic [15:0]  s_rate_z,
    input  logic         s_restart,

    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_dac_level_0,
    output logic [7:0]   m_dac_level_1,
    output logic [7:0]   m_dac_level_2,
    output logic [2:0]   m_axis_faults,
    output logic [1:0]   m_axes_in_range,
    output logic [6:0]   m_settle_wait,
    output logic         m_finished
);

    localparam iter_t ITER_FULL = ITER_W'(ITERATIONS);
    localparam iter_t ITER_TAIL = ITER_W'(TAIL_ITERATIONS);

    // configuration
    factor_t xy_ovs_reg;
    factor_t z_ovs_reg;

    // input stage
    logic    in_valid_reg;
    rate_t   in_rate_reg [NUM_AXES];
    logic    in_restart_reg;

    // calibration state
    level_t  lvl_reg [NUM_AXES];
    logic [2:0] fault_reg;
    iter_t   iter_reg;
    logic [1:0] prev_reg;

    // result stage
    logic    out_valid_reg;
    level_t  out_lvl_reg [NUM_AXES];
    logic [2:0] out_fault_reg;
    logic [1:0] out_count_reg;
    wait_t   out_wait_reg;
    logic    out_done_reg;

    // combinational results
    logic    out_adv;
    logic    stage_move;
    iter_t   iter_eff;
    logic [1:0] prev_eff;
    logic    idle_done;
    iter_t   left_cur;
    iter_t   left_next;
    level_t  lvl_next [NUM_AXES];
    logic [2:0] fault_next;
    logic [NUM_AXES-1:0] in_win;
    logic [1:0] count;
    logic    done_now;
    wait_t   wait_now;

    assign out_adv    = !out_valid_reg || m_ready;
    assign stage_move = in_valid_reg && out_adv;
    assign s_ready    = !in_valid_reg || out_adv;

    // apply restart and tail shortening, then step the counter
    always_comb begin
        iter_eff  = in_restart_reg ? ITER_FULL : iter_reg;
        prev_eff  = in_restart_reg ? 2'd0 : prev_reg;
        idle_done = (iter_eff == '0);
        if (prev_eff == 2'd3 && iter_eff > ITER_TAIL) begin
            left_cur = ITER_TAIL;
        end else begin
            left_cur = iter_eff;
        end
        left_next = left_cur - ITER_W'(1);
    end

    // step each axis against its window and clamp
    always_comb begin
        logic [THR_W-1:0] lo_thr;
        logic [THR_W-1:0] hi_thr;
        logic [THR_W-1:0] reading;
        logic [LEVEL_W:0] lvl;
        factor_t          factor;
        for (int a = 0; a < NUM_AXES; a++) begin
            lvl_next[a] = lvl_reg[a];
        end
        fault_next = fault_reg;
        for (int a = 0; a < NUM_AXES; a++) begin
            factor  = (a == NUM_AXES - 1) ? z_ovs_reg : xy_ovs_reg;
            lo_thr  = THR_W'(LOW_MULT) * THR_W'(factor);
            hi_thr  = THR_W'(HIGH_MULT) * THR_W'(factor);
            reading = THR_W'(in_rate_reg[a]);
            lvl     = {1'b0, lvl_reg[AXIS_CHANNEL[a]]};
            in_win[a] = 1'b0;
            if (reading < lo_thr) begin
                lvl = lvl - (LEVEL_W+1)'(1);
            end else if (reading > hi_thr) begin
                lvl = lvl + (LEVEL_W+1)'(1);
            end else begin
                in_win[a] = 1'b1;
            end
            if (lvl < {1'b0, LEVEL_MIN}) begin
                lvl = {1'b0, LEVEL_MIN};
                fault_next[a] = 1'b1;
            end else if (lvl > {1'b0, LEVEL_MAX}) begin
                lvl = {1'b0, LEVEL_MAX};
                fault_next[a] = 1'b1;
            end
            lvl_next[AXIS_CHANNEL[a]] = lvl[LEVEL_W-1:0];
        end
        count = 2'(in_win[0]) + 2'(in_win[1]) + 2'(in_win[2]);
    end

    // pick the settle wait
    always_comb begin
        done_now = idle_done || (left_next == '0);
        if (done_now) begin
            wait_now = WAIT_DONE;
        end else if (left_next <= ITER_TAIL) begin
            wait_now = WAIT_TAIL;
        end else begin
            wait_now = WAIT_FAST;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xy_ovs_reg <= FACTOR_RESET;
            z_ovs_reg  <= FACTOR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_XY_OVS: xy_ovs_reg <= cfg_data;
                REG_Z_OVS:  z_ovs_reg  <= cfg_data;
                default:    xy_ovs_reg <= xy_ovs_reg;
            endcase
        end
    end

    // capture the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_rate_reg[0] <= s_rate_x;
            in_rate_reg[1] <= s_rate_y;
            in_rate_reg[2] <= s_rate_z;
            in_restart_reg <= s_restart;
        end
    end

    // advance calibration state as a beat leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                lvl_reg[c] <= LEVEL_RESET;
            end
            fault_reg <= '0;
            iter_reg  <= ITER_FULL;
            prev_reg  <= '0;
        end else if (stage_move && !idle_done) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                lvl_reg[c] <= lvl_next[c];
            end
            fault_reg <= fault_next;
            iter_reg  <= left_next;
            prev_reg  <= count;
        end
    end

    // hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
        if (stage_move) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                out_lvl_reg[c] <= idle_done ? lvl_reg[c] : lvl_next[c];
            end
            out_fault_reg <= idle_done ? fault_reg : fault_next;
            out_count_reg <= idle_done ? 2'd0 : count;
            out_wait_reg  <= wait_now;
            out_done_reg  <= done_now;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_dac_level_0   = out_lvl_reg[0];
    assign m_dac_level_1   = out_lvl_reg[1];
    assign m_dac_level_2   = out_lvl_reg[2];
    assign m_axis_faults   = out_fault_reg;
    assign m_axes_in_range = out_count_reg;
    assign m_settle_wait   = out_wait_reg;
    assign m_finished      = out_done_reg;

`ifndef SYNTHESIS
    // offsets never leave the clamp window
    a_level_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (lvl_reg[0] >= LEVEL_MIN && lvl_reg[0] <= LEVEL_MAX &&
         lvl_reg[1] >= LEVEL_MIN && lvl_reg[1] <= LEVEL_MAX &&
         lvl_reg[2] >= LEVEL_MIN && lvl_reg[2] <= LEVEL_MAX))
        else $error("offset level outside clamp window");

    // fault flags are sticky
    a_fault_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((fault_reg & $past(fault_reg)) == $past(fault_reg)))
        else $error("fault flag cleared");

    // a finished beat always carries the long settle wait
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_done_reg) |-> (out_wait_reg == WAIT_DONE))
        else $error("finished beat without done wait");

    // counter never exceeds its reload value
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= ITER_FULL)
        else $error("iteration counter above reload value");
`endif

endmodule

// File: tb/tb_gyro_dac_offset_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gyro_dac_offset_calibrator: self-checking bench for the offset calibrator
// Drives rate beats through valid/ready with random gaps and back-pressure and
// checks every result beat against a cycle-free model of the offset stepping,
// clamping, fault flags and iteration count. The run goes through several
// oversampling settings, written only while the block is empty.
// ----------------------------------------------------------------------------
module tb_gyro_dac_offset_calibrator;
    import gdoc_pkg::*;

    localparam int ITERATIONS      = 200;
    localparam int TAIL_ITERATIONS = 10;
    localparam int RATE_MAX        = 65535;
    localparam int NUM_PHASES      = 5;
    localparam int PHASE_BEATS     = 165;
    localparam int SETTLE_CYCLES   = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 100;

    // window edges at the reset factor
    localparam rate_t LO_RESET = LOW_MULT * FACTOR_RESET;
    localparam rate_t HI_RESET = HIGH_MULT * FACTOR_RESET;

    typedef struct packed {
        rate_t rate_x;
        rate_t rate_y;
        rate_t rate_z;
        logic  restart;
    } rate_sample_t;

    typedef struct packed {
        level_t     lvl0;
        level_t     lvl1;
        level_t     lvl2;
        logic [2:0] faults;
        logic [1:0] in_range;
        wait_t      settle;
        logic       finished;
    } dac_result_t;

    typedef enum int {K_BELOW, K_WINDOW, K_ABOVE, K_ANY} reading_kind_e;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    logic [15:0] s_rate_x;
    logic [15:0] s_rate_y;
    logic [15:0] s_rate_z;
    logic       s_restart;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_dac_level_0;
    logic [7:0] m_dac_level_1;
    logic [7:0] m_dac_level_2;
    logic [2:0] m_axis_faults;
    logic [1:0] m_axes_in_range;
    logic [6:0] m_settle_wait;
    logic       m_finished;

    // pending beats and expected results
    rate_sample_t sample_q [$];
    dac_result_t  dac_result_q [$];

    // model state
    level_t     offsets [NUM_AXES];
    logic [2:0] fault_flags;
    iter_t      iters_left;
    logic [1:0] prev_hits;
    factor_t    xy_factor;
    factor_t    z_factor;

    // random sequence state
    int            seq_left;
    reading_kind_e axis_bias [NUM_AXES];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   live_beats;
    int   err_cnt;
    int   stall_cycles;
    logic in_taken;
    rate_sample_t cur_sample;

    gyro_dac_offset_calibrator #(
        .ITERATIONS      (ITERATIONS),
        .TAIL_ITERATIONS (TAIL_ITERATIONS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rate_x        (s_rate_x),
        .s_rate_y        (s_rate_y),
        .s_rate_z        (s_rate_z),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dac_level_0   (m_dac_level_0),
        .m_dac_level_1   (m_dac_level_1),
        .m_dac_level_2   (m_dac_level_2),
        .m_axis_faults   (m_axis_faults),
        .m_axes_in_range (m_axes_in_range),
        .m_settle_wait   (m_settle_wait),
        .m_finished      (m_finished)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Step the offsets for one beat and return the result it should produce
    function automatic dac_result_t predict_offsets(rate_sample_t s);
        dac_result_t r;
        bit          ignored;
        int          lvl;
        int          left;
        int          ch;
        logic [1:0]  hits;
        logic [THR_W-1:0] lo_thr;
        logic [THR_W-1:0] hi_thr;
        factor_t     f;
        rate_t       rd;
        hits = '0;
        if (s.restart) begin
            iters_left = iter_t'(ITERATIONS);
            prev_hits  = '0;
        end
        ignored = (iters_left == 0);
        if (!ignored) begin
            // shorten once every axis sat inside the window
            left = int'(iters_left);
            if (prev_hits == 2'd3 && left > TAIL_ITERATIONS)
                left = TAIL_ITERATIONS;
            for (int a = 0; a < NUM_AXES; a++) begin
                f      = (a == 2) ? z_factor : xy_factor;
                rd     = (a == 0) ? s.rate_x : (a == 1) ? s.rate_y : s.rate_z;
                lo_thr = LOW_MULT * f;
                hi_thr = HIGH_MULT * f;
                ch     = AXIS_CHANNEL[a];
                lvl    = int'(offsets[ch]);
                if (rd < lo_thr)
                    lvl = lvl - 1;
                else if (rd > hi_thr)
                    lvl = lvl + 1;
                else
                    hits = hits + 2'd1;
                // clamp and latch the axis fault
                if (lvl < int'(LEVEL_MIN)) begin
                    lvl = int'(LEVEL_MIN);
                    fault_flags[a] = 1'b1;
                end else if (lvl > int'(LEVEL_MAX)) begin
                    lvl = int'(LEVEL_MAX);
                    fault_flags[a] = 1'b1;
                end
                offsets[ch] = level_t'(lvl);
            end
            prev_hits  = hits;
            iters_left = iter_t'(left - 1);
        end
        r.lvl0     = offsets[0];
        r.lvl1     = offsets[1];
        r.lvl2     = offsets[2];
        r.faults   = fault_flags;
        r.in_range = hits;
        r.finished = (iters_left == 0);
        if (r.finished)
            r.settle = WAIT_DONE;
        else if (iters_left <= TAIL_ITERATIONS)
            r.settle = WAIT_TAIL;
        else
            r.settle = WAIT_FAST;
        return r;
    endfunction

    // Pick a reading below, inside or above the window of factor f
    function automatic rate_t pick_rate(reading_kind_e kind, factor_t f);
        int lo;
        int hi;
        int top;
        bit at_bound;
        lo       = LOW_MULT * f;
        hi       = HIGH_MULT * f;
        at_bound = ($urandom_range(3, 0) == 0);
        case (kind)
            K_BELOW: begin
                if (lo == 0)
                    return '0;
                top = (lo - 1 > RATE_MAX) ? RATE_MAX : lo - 1;
                return at_bound ? rate_t'(top) : rate_t'($urandom_range(top, 0));
            end
            K_WINDOW: begin
                if (lo > RATE_MAX)
                    return rate_t'(RATE_MAX);
                top = (hi > RATE_MAX) ? RATE_MAX : hi;
                if (at_bound)
                    return $urandom_range(1, 0) ? rate_t'(lo) : rate_t'(top);
                return rate_t'($urandom_range(top, lo));
            end
            K_ABOVE: begin
                if (hi >= RATE_MAX)
                    return rate_t'(RATE_MAX);
                return at_bound ? rate_t'(hi + 1) : rate_t'($urandom_range(RATE_MAX, hi + 1));
            end
            default: return rate_t'($urandom_range(RATE_MAX, 0));
        endcase
    endfunction

    // Mostly biased runs that drift the offsets; some plain noise
    function automatic rate_sample_t next_random_sample();
        rate_sample_t  s;
        reading_kind_e kind;
        rate_t         rd [NUM_AXES];
        bit            all_window;
        if ($urandom_range(9, 0) == 0) begin
            s.rate_x  = rate_t'($urandom_range(RATE_MAX, 0));
            s.rate_y  = rate_t'($urandom_range(RATE_MAX, 0));
            s.rate_z  = rate_t'($urandom_range(RATE_MAX, 0));
            s.restart = ($urandom_range(3, 0) == 0);
            return s;
        end
        s.restart = 1'b0;
        if (seq_left == 0) begin
            seq_left   = $urandom_range(120, 8);
            all_window = ($urandom_range(9, 0) < 3);
            for (int a = 0; a < NUM_AXES; a++)
                axis_bias[a] = all_window ? K_WINDOW : reading_kind_e'($urandom_range(3, 0));
            s.restart = ($urandom_range(9, 0) < 4);
        end
        seq_left = seq_left - 1;
        for (int a = 0; a < NUM_AXES; a++) begin
            kind  = ($urandom_range(4, 0) != 0) ? axis_bias[a]
                                                : reading_kind_e'($urandom_range(3, 0));
            rd[a] = pick_rate(kind, (a == 2) ? z_factor : xy_factor);
        end
        s.rate_x = rd[0];
        s.rate_y = rd[1];
        s.rate_z = rd[2];
        return s;
    endfunction

    task automatic push_sample(int x, int y, int z, bit restart);
        rate_sample_t s;
        s.rate_x  = rate_t'(x);
        s.rate_y  = rate_t'(y);
        s.rate_z  = rate_t'(z);
        s.restart = restart;
        sample_q.push_back(s);
    endtask

    task automatic write_reg(logic idx, logic [7:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every beat is sent and every result is back, then let the pipe settle
    task automatic wait_all_done();
        while (sample_q.size() != 0 || s_valid || dac_result_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            if (err_cnt < MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // Driver: present the next beat or a gap, toggle back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (sample_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    cur_sample = sample_q.pop_front();
                    s_valid   <= 1'b1;
                    s_rate_x  <= cur_sample.rate_x;
                    s_rate_y  <= cur_sample.rate_y;
                    s_rate_z  <= cur_sample.rate_z;
                    s_restart <= cur_sample.restart;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Monitor: track config, predict on input beats, check result beats
    always @(posedge aclk) begin
        dac_result_t want;
        dac_result_t got;
        if (!aresetn) begin
            for (int c = 0; c < NUM_AXES; c++)
                offsets[c] = LEVEL_RESET;
            fault_flags = '0;
            iters_left  = iter_t'(ITERATIONS);
            prev_hits   = '0;
            xy_factor   = FACTOR_RESET;
            z_factor    = FACTOR_RESET;
            in_taken   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_XY_OVS: xy_factor = cfg_data;
                    REG_Z_OVS:  z_factor  = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (dac_result_q.size() == 0) begin
                    $error("result beat with no expected result pending");
                    err_cnt++;
                end else begin
                    want = dac_result_q.pop_front();
                    got.lvl0     = m_dac_level_0;
                    got.lvl1     = m_dac_level_1;
                    got.lvl2     = m_dac_level_2;
                    got.faults   = m_axis_faults;
                    got.in_range = m_axes_in_range;
                    got.settle   = m_settle_wait;
                    got.finished = m_finished;
                    check_field("dac_level_0", want.lvl0, got.lvl0);
                    check_field("dac_level_1", want.lvl1, got.lvl1);
                    check_field("dac_level_2", want.lvl2, got.lvl2);
                    check_field("axis_faults", want.faults, got.faults);
                    check_field("axes_in_range", want.in_range, got.in_range);
                    check_field("settle_wait", want.settle, got.settle);
                    check_field("finished", want.finished, got.finished);
                end
            end
            if (s_valid && s_ready) begin
                cur_sample.rate_x  = s_rate_x;
                cur_sample.rate_y  = s_rate_y;
                cur_sample.rate_z  = s_rate_z;
                cur_sample.restart = s_restart;
                dac_result_q.push_back(predict_offsets(cur_sample));
                live_beats++;
            end
            in_taken <= s_valid && s_ready;
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_gyro_dac_offset_calibrator failed");
                $finish;
            end
        end
    end

    initial begin
        int xy_plan   [NUM_PHASES];
        int z_plan    [NUM_PHASES];
        int send_plan [NUM_PHASES];
        int recv_plan [NUM_PHASES];
        int goal;
        xy_plan   = '{4, 1, 128, 0, 0};
        z_plan    = '{4, 128, 1, 255, 0};
        send_plan = '{0, 55, 0, 26, 26};
        recv_plan = '{0, 0, 55, 26, 26};
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_XY_OVS;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_rate_x       = '0;
        s_rate_y       = '0;
        s_rate_z       = '0;
        s_restart      = 1'b0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        live_beats     = 0;
        err_cnt        = 0;
        stall_cycles   = 0;
        seq_left       = 0;
        in_taken       = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // reprogram the factors only while the pipe is empty
            if (p != 0) begin
                if (p == NUM_PHASES - 1) begin
                    xy_plan[p] = $urandom_range(128, 1);
                    z_plan[p]  = $urandom_range(128, 1);
                end
                write_reg(REG_XY_OVS, xy_plan[p][7:0]);
                write_reg(REG_Z_OVS, z_plan[p][7:0]);
            end
            send_idle_pct  = send_plan[p];
            recv_stall_pct = recv_plan[p];

            if (p == 0) begin
                // extremes, window edges, tail shortening, finish, ignored beats, restart
                push_sample(0, 0, 0, 1'b0);
                push_sample(RATE_MAX, RATE_MAX, RATE_MAX, 1'b0);
                push_sample(LO_RESET, LO_RESET, LO_RESET, 1'b0);
                push_sample(HI_RESET, HI_RESET, HI_RESET, 1'b0);
                push_sample(LO_RESET - 1, HI_RESET + 1, LO_RESET + 10, 1'b0);
                repeat (8) push_sample(LO_RESET + 5, HI_RESET - 5, LO_RESET + 10, 1'b0);
                push_sample(0, RATE_MAX, 16'hAAAA, 1'b0);
                push_sample(16'h5555, 16'hAAAA, 16'h1234, 1'b0);
                push_sample(LO_RESET + 10, LO_RESET + 10, LO_RESET + 10, 1'b1);
                push_sample(LO_RESET, HI_RESET, LO_RESET + 10, 1'b1);
            end

            goal = live_beats + PHASE_BEATS;
            while (live_beats < goal) begin
                if (sample_q.size() < 4)
                    sample_q.push_back(next_random_sample());
                else
                    @(posedge aclk);
            end
            wait_all_done();
        end

        if (dac_result_q.size() != 0) begin
            $error("%0d expected results never arrived", dac_result_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_gyro_dac_offset_calibrator passed");
        else
            $display("tb_gyro_dac_offset_calibrator failed");
        $finish;
    end

endmodule

// File: sim.f
sv/gdoc_pkg.sv
sv/gyro_dac_offset_calibrator.sv
tb/tb_gyro_dac_offset_calibrator.sv
